>>> rtl/lsfc_pkg.sv
package lsfc_pkg;

    localparam int RANGE_BITS  = 16;
    localparam int MAX_SAMPLES = 1024;
    localparam int WIN         = 12;
    localparam int LAG         = 6;
    localparam int SLOPE_SPAN  = 3;
    localparam int SEG_BACK    = 5;

    localparam int DIST_W      = 16;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;

    localparam int COUNT_W     = 11;
    localparam int COUNT_MAX   = 2**COUNT_W - 1;
    localparam int INDEX_W     = 10;
    localparam int INDEX_CAP   = (MAX_SAMPLES - 1 < 2**INDEX_W - 1) ?
                                 MAX_SAMPLES - 1 : 2**INDEX_W - 1;
    localparam int CLASS_W     = 3;
    localparam int OFF_W       = 3;

    localparam int NUM_AGES    = LAG + 1;
    localparam int NUM_SLOPES  = WIN - SLOPE_SPAN;
    localparam int T_N         = SEG_BACK + SLOPE_SPAN + 1;
    localparam int EXT_N       = 2 * SLOPE_SPAN + NUM_SLOPES;
    localparam int EXT_W       = $clog2(EXT_N);

    localparam int SLOPE_W     = RANGE_BITS + 1;
    localparam int DIFF_W      = RANGE_BITS + 2;

    localparam int THR_W       = 16;
    localparam int MAXR_W      = 16;
    localparam int LIMIT_W     = 17;
    localparam int CFG_W       = 17;
    localparam int CFG_ADDR_W  = 2;

    localparam int JCMP_W      = (RANGE_BITS > THR_W) ? RANGE_BITS : THR_W;
    localparam int RCMP_W      = (RANGE_BITS > MAXR_W) ? RANGE_BITS : MAXR_W;
    localparam int SCMP_W      = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_ADDR_W-1:0] REG_BREAK_THR      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STRAIGHT_LIMIT = 2'd2;

    localparam logic [THR_W-1:0]   RESET_BREAK_THR      = 16'd100;
    localparam logic [MAXR_W-1:0]  RESET_MAX_RANGE      = 16'd4000;
    localparam logic [LIMIT_W-1:0] RESET_STRAIGHT_LIMIT = 17'd50;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE    = 3'd0,
        CLASS_BREAK   = 3'd1,
        CLASS_CORNER  = 3'd2,
        CLASS_SEGMENT = 3'd3,
        CLASS_CURVE   = 3'd4
    } feature_class_t;

    typedef struct packed {
        logic [THR_W-1:0]   break_thr;
        logic [MAXR_W-1:0]  max_range;
        logic [LIMIT_W-1:0] straight_limit;
    } cfg_t;

    typedef struct packed {
        logic                                   last;
        logic [COUNT_W-1:0]                     pos;
        logic [OFF_W-1:0]                       off_start;
        logic [NUM_AGES-1:0]                    none_flags;
        logic [NUM_AGES-1:0]                    jump_flags;
        logic [NUM_SLOPES-1:0][SLOPE_W-1:0]     slopes;
    } job_t;

endpackage

>>> rtl/lsfc_front.sv
module lsfc_front
    import lsfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] distance
    input  logic                s_tlast,
    input  cfg_t                cfg,
    input  logic                q_full,
    output logic                push,
    output job_t                push_job
);

    logic [RANGE_BITS-1:0] window_reg [WIN];
    logic [RANGE_BITS-1:0] w_shift    [WIN];
    logic [COUNT_W-1:0]    count_reg;
    logic                  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        w_shift[0] = s_tdata[RANGE_BITS-1:0];
        for (int a = 1; a < WIN; a++) begin
            w_shift[a] = window_reg[a-1];
        end
    end

    always_comb begin
        logic signed [SLOPE_W-1:0] jd;
        logic [SLOPE_W-1:0]        jmag;
        push_job.last = s_tlast;
        push_job.pos  = count_reg;
        if (s_tlast && count_reg < COUNT_W'(LAG)) begin
            push_job.off_start = count_reg[OFF_W-1:0];
        end else begin
            push_job.off_start = OFF_W'(LAG);
        end
        for (int a = 0; a < NUM_AGES; a++) begin
            push_job.none_flags[a] =
                RCMP_W'(w_shift[a]) >= RCMP_W'(cfg.max_range);
            jd = $signed({1'b0, w_shift[a+1]}) - $signed({1'b0, w_shift[a]});
            jmag = jd[SLOPE_W-1] ? SLOPE_W'(-jd) : SLOPE_W'(jd);
            push_job.jump_flags[a] = JCMP_W'(jmag[RANGE_BITS-1:0]) > JCMP_W'(cfg.break_thr);
        end
        for (int k = 0; k < NUM_SLOPES; k++) begin
            if (count_reg >= COUNT_W'(k + SLOPE_SPAN)) begin
                push_job.slopes[k] = $signed({1'b0, w_shift[k]})
                                   - $signed({1'b0, w_shift[k+SLOPE_SPAN]});
            end else begin
                push_job.slopes[k] = '0;
            end
        end
        jd   = '0;
        jmag = '0;
    end

    assign push = accept && (s_tlast || count_reg >= COUNT_W'(LAG));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int a = 0; a < WIN; a++) begin
                window_reg[a] <= '0;
            end
        end else if (accept) begin
            if (s_tlast) begin
                count_reg <= '0;
                for (int a = 0; a < WIN; a++) begin
                    window_reg[a] <= '0;
                end
            end else begin
                if (count_reg != COUNT_W'(COUNT_MAX)) begin
                    count_reg <= count_reg + 1'b1;
                end
                for (int a = 0; a < WIN; a++) begin
                    window_reg[a] <= w_shift[a];
                end
            end
        end
    end

endmodule

>>> rtl/lsfc_queue.sv
module lsfc_queue
    import lsfc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    assign full       = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/lsfc_back.sv
module lsfc_back
    import lsfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  job_t                head_job,
    input  cfg_t                cfg,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [9:0] sample_index, [12:10] feature_class
    output logic                m_tlast
);

    logic                      active_reg;
    logic [OFF_W-1:0]          off_reg;
    logic                      m_tvalid_reg;
    logic [INDEX_W-1:0]        index_reg;
    feature_class_t            class_reg;
    logic                      end_reg;

    logic [OFF_W-1:0]          off;
    logic [OFF_W-1:0]          off_lo;
    logic                      emit;
    logic signed [SLOPE_W-1:0] ext [EXT_N];
    logic signed [SLOPE_W-1:0] t   [T_N];
    logic [T_N-1:0]            pos_s;
    logic [T_N-1:0]            neg_s;
    logic                      straight;
    logic                      corner;
    logic                      is_break;
    logic [COUNT_W-1:0]        pos_i;
    logic [INDEX_W-1:0]        index_c;
    feature_class_t            class_c;

    assign off    = active_reg ? off_reg : head_job.off_start;
    assign off_lo = head_job.last ? '0 : OFF_W'(LAG);
    assign emit   = head_valid && (!m_tvalid_reg || m_tready);
    assign pop    = emit && (off == off_lo);

    always_comb begin
        logic [EXT_W-1:0] idx;
        for (int e = 0; e < 2 * SLOPE_SPAN; e++) begin
            ext[e] = '0;
        end
        for (int k = 0; k < NUM_SLOPES; k++) begin
            ext[k + 2 * SLOPE_SPAN] = $signed(head_job.slopes[k]);
        end
        for (int n = 0; n < T_N; n++) begin
            idx   = EXT_W'(off) + EXT_W'(SEG_BACK + SLOPE_SPAN - n);
            t[n]  = ext[idx];
            neg_s[n] = t[n][SLOPE_W-1];
            pos_s[n] = !t[n][SLOPE_W-1] && (t[n] != '0);
        end
    end

    function automatic logic same_sign(input logic pa, input logic na,
                                       input logic pb, input logic nb);
        return (pa && pb) || (na && nb);
    endfunction

    always_comb begin
        corner = ((pos_s[6] && neg_s[4]) || (neg_s[6] && pos_s[4]))
              && same_sign(pos_s[3], neg_s[3], pos_s[4], neg_s[4])
              && same_sign(pos_s[5], neg_s[5], pos_s[6], neg_s[6])
              && same_sign(pos_s[2], neg_s[2], pos_s[3], neg_s[3])
              && same_sign(pos_s[6], neg_s[6], pos_s[7], neg_s[7])
              && same_sign(pos_s[1], neg_s[1], pos_s[2], neg_s[2])
              && same_sign(pos_s[7], neg_s[7], pos_s[8], neg_s[8]);
    end

    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        mag;
        straight = 1'b1;
        for (int q = 0; q < T_N - 2; q++) begin
            d   = DIFF_W'(t[q+1]) - DIFF_W'(t[q]);
            mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            if (!(SCMP_W'(mag) < SCMP_W'(cfg.straight_limit))) begin
                straight = 1'b0;
            end
        end
    end

    always_comb begin
        is_break = (off == '0) || (COUNT_W'(off) == head_job.pos)
                || head_job.jump_flags[off];
        if (off != '0) begin
            is_break = is_break || head_job.jump_flags[off - 1'b1];
        end
        priority if (head_job.none_flags[off]) begin
            class_c = CLASS_NONE;
        end else if (is_break) begin
            class_c = CLASS_BREAK;
        end else if (corner) begin
            class_c = CLASS_CORNER;
        end else if (straight) begin
            class_c = CLASS_SEGMENT;
        end else begin
            class_c = CLASS_CURVE;
        end
    end

    assign pos_i   = head_job.pos - COUNT_W'(off);
    assign index_c = (pos_i > COUNT_W'(INDEX_CAP)) ? INDEX_W'(INDEX_CAP)
                                                   : pos_i[INDEX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            off_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                if (pop) begin
                    active_reg <= 1'b0;
                end else begin
                    active_reg <= 1'b1;
                    off_reg    <= off - 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            index_reg <= index_c;
            class_reg <= class_c;
            end_reg   <= head_job.last && (off == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - INDEX_W - CLASS_W)'(0), class_reg, index_reg};
    assign m_tlast  = end_reg;

    a_flush_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> head_valid)
        else $error("flush in progress without a job at the queue head");

    a_single_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && !head_job.last |-> !active_reg && off == OFF_W'(LAG))
        else $error("mid-scan job not at the lag offset");

    a_flush_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && head_job.last |-> off <= head_job.off_start)
        else $error("flush offset above its start");

    a_end_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && head_job.last && off == '0 |-> pop)
        else $error("final sample emitted without retiring the job");

endmodule

>>> rtl/lidar_scan_feature_classifier_core.sv
// Classifies a stream of scan ranges, one sample per clock while the job
// queue is not full, into none, breakpoint, corner, segment or curve. A
// sample's result leaves once the sample six positions later is taken, so
// the first six samples of a scan produce nothing at first; the transaction
// with tlast set then flushes every pending sample, up to seven results, one
// per cycle while m_tready allows, the last one carrying m_tlast. The front
// end builds each job combinationally; results pass through a four-entry
// job queue to the back end, which emits one result per cycle while m_tready
// allows, so input keeps flowing during a flush until the queue fills.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata by the user
// only while no scan is in flight, which the block does not enforce; index
// 0 break threshold, 1 max range, 2 straight limit.
module lidar_scan_feature_classifier_core
    import lsfc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] distance
    input  logic                  s_tlast,   // last_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [9:0] sample_index, [12:10] feature_class
    output logic                  m_tlast,   // scan_end
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    cfg_t cfg_reg;
    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.break_thr      <= RESET_BREAK_THR;
            cfg_reg.max_range      <= RESET_MAX_RANGE;
            cfg_reg.straight_limit <= RESET_STRAIGHT_LIMIT;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_BREAK_THR) begin
                cfg_reg.break_thr <= cfg_wdata[THR_W-1:0];
            end
            if (cfg_addr == REG_MAX_RANGE) begin
                cfg_reg.max_range <= cfg_wdata[MAXR_W-1:0];
            end
            if (cfg_addr == REG_STRAIGHT_LIMIT) begin
                cfg_reg.straight_limit <= cfg_wdata[LIMIT_W-1:0];
            end
        end
    end

    lsfc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    lsfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    lsfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .cfg        (cfg_reg),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
